[src/mcpr_pkg.sv]
// package: shared constants, types and arithmetic helpers for the chain product block
`timescale 1ns / 1ps
package mcpr_pkg;
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int OUT_BITS = 48;
	localparam int ACC_BITS = 64;
	localparam int STORE_DEPTH = 128;
	localparam int ADDR_BITS = $clog2(STORE_DEPTH);
	localparam int PROD_BITS = 2 * WORD_BITS;

	// matrix numbers
	localparam logic [3:0] M_LT0T = 4'd0;
	localparam logic [3:0] M_LTT = 4'd1;
	localparam logic [3:0] M_LT0T1 = 4'd2;
	localparam logic [3:0] M_LTT1 = 4'd3;
	localparam logic [3:0] M_LTTR = 4'd4;
	localparam logic [3:0] M_LTT1R = 4'd5;
	localparam logic [3:0] M_RT = 4'd6;
	localparam logic [3:0] M_RS = 4'd7;
	localparam logic [3:0] M_RT1 = 4'd8;
	localparam logic [3:0] M_RS1 = 4'd9;
	localparam logic [3:0] M_RTR = 4'd10;
	localparam logic [3:0] M_RT1R = 4'd11;
	localparam logic [3:0] M_A0 = 4'd12;
	localparam logic [3:0] T_VEC1 = 4'd13;
	localparam logic [3:0] T_VEC2 = 4'd14;
	localparam logic [3:0] T_NONE = 4'd15;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	localparam int VEC1_BASE = 117;
	localparam int VEC2_BASE = 120;
	localparam int NCHAINS = 12;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [ACC_BITS-1:0] acc_t;

	// chain table: twelve chains of four matrices, first eight feed v1
	function automatic logic [3:0] chain_mat(input logic [3:0] ch, input logic [1:0] pos);
		logic [15:0] row;
		begin
			case (ch)
				4'd0: row = {M_LT0T, M_RT, M_LTT, M_RT1R};
				4'd1: row = {M_LT0T, M_RT, M_LTTR, M_RS1};
				4'd2: row = {M_LT0T, M_RT, M_LTT1, M_RTR};
				4'd3: row = {M_LT0T, M_RT, M_LTT1R, M_RS};
				4'd4: row = {M_LT0T, M_RT1, M_LTT, M_RTR};
				4'd5: row = {M_LT0T, M_RT1, M_LTTR, M_RS};
				4'd6: row = {M_LT0T1, M_RT, M_LTT, M_RTR};
				4'd7: row = {M_LT0T1, M_RT, M_LTTR, M_RS};
				4'd8: row = {M_LT0T, M_RT, M_LTT, M_RS1};
				4'd9: row = {M_LT0T, M_RT, M_LTT1, M_RS};
				4'd10: row = {M_LT0T, M_RT1, M_LTT, M_RS};
				4'd11: row = {M_LT0T1, M_RT, M_LTT, M_RS};
				default: row = '0;
			endcase
			chain_mat = row[pos*4 +: 4];
		end
	endfunction

	// store address of matrix element
	function automatic logic [ADDR_BITS-1:0] mat_addr(input logic [3:0] t,
			input logic [1:0] r, input logic [1:0] c);
		logic [ADDR_BITS+1:0] a;
		begin
			a = ({2'b0, t, 3'b0} + {4'b0, t}) + ({4'b0, r, 1'b0} + {6'b0, r})
				+ {6'b0, c};
			mat_addr = a[ADDR_BITS-1:0];
		end
	endfunction

	// saturate 64-bit sum to word width
	function automatic word_t sat_word(input acc_t v, output logic ov);
		acc_t hi;
		acc_t lo;
		begin
			hi = (acc_t'(1) <<< (WORD_BITS - 1)) - acc_t'(1);
			lo = -hi - acc_t'(1);
			ov = 1'b0;
			if (v > hi) begin
				ov = 1'b1;
				sat_word = hi[WORD_BITS-1:0];
			end else if (v < lo) begin
				ov = 1'b1;
				sat_word = lo[WORD_BITS-1:0];
			end else begin
				sat_word = v[WORD_BITS-1:0];
			end
		end
	endfunction
endpackage

[src/mcpr_ram.sv]
// generic ram with one write port and one read port, registered read
`timescale 1ns / 1ps
module mcpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[src/mcpr_mac.sv]
// shared multiply unit: floor product shift with word saturation, registered
`timescale 1ns / 1ps
module mcpr_mac (
	input  logic               clk,
	input  mcpr_pkg::word_t    a,
	input  mcpr_pkg::word_t    b,
	output mcpr_pkg::word_t    prod_s1,
	output logic               ov_s1
);
	logic signed [mcpr_pkg::PROD_BITS-1:0] full;
	logic signed [mcpr_pkg::PROD_BITS-1:0] shifted;
	logic signed [mcpr_pkg::PROD_BITS-1:0] hi;
	logic signed [mcpr_pkg::PROD_BITS-1:0] lo;

	// arithmetic shift floors toward minus infinity
	always_comb begin
		full = mcpr_pkg::PROD_BITS'(a) * mcpr_pkg::PROD_BITS'(b);
		shifted = full >>> mcpr_pkg::FRAC_BITS;
		hi = (mcpr_pkg::PROD_BITS'(1) <<< (mcpr_pkg::WORD_BITS - 1)) - 1;
		lo = -hi - 1;
	end

	always_ff @(posedge clk) begin
		if (shifted > hi) begin
			prod_s1 <= hi[mcpr_pkg::WORD_BITS-1:0];
			ov_s1 <= 1'b1;
		end else if (shifted < lo) begin
			prod_s1 <= lo[mcpr_pkg::WORD_BITS-1:0];
			ov_s1 <= 1'b1;
		end else begin
			prod_s1 <= shifted[mcpr_pkg::WORD_BITS-1:0];
			ov_s1 <= 1'b0;
		end
	end
endmodule

[src/mcpr_seq.sv]
// sequencer: loads, chain products, chain sums, matrix-vector and final dot
`timescale 1ns / 1ps
module mcpr_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [3:0]                target,
	input  logic [1:0]                row,
	input  logic [1:0]                column,
	input  logic signed [31:0]        value,
	input  logic [1:0]                alpha,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic signed [47:0]        res_scalar,
	output logic                      res_ov,
	output logic                      ram_we,
	output logic [mcpr_pkg::ADDR_BITS-1:0] ram_waddr,
	output mcpr_pkg::word_t           ram_wdata,
	output logic [mcpr_pkg::ADDR_BITS-1:0] ram_raddr,
	input  mcpr_pkg::word_t           ram_rdata,
	output mcpr_pkg::word_t           mul_a,
	output mcpr_pkg::word_t           mul_b,
	input  mcpr_pkg::word_t           mul_p,
	input  logic                      mul_ov
);
	// states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR = 4'd1;
	localparam logic [3:0] S_COL = 4'd2;
	localparam logic [3:0] S_LDA = 4'd3;
	localparam logic [3:0] S_LDB = 4'd4;
	localparam logic [3:0] S_MUL = 4'd5;
	localparam logic [3:0] S_ACC = 4'd6;
	localparam logic [3:0] S_SUM = 4'd7;
	localparam logic [3:0] S_MV = 4'd8;
	localparam logic [3:0] S_DOT = 4'd9;
	localparam logic [3:0] S_OUT = 4'd10;

	logic [3:0] state_q;
	logic [mcpr_pkg::ADDR_BITS:0] clr_q;
	logic [3:0] cnt_q;
	logic [1:0] alpha_q;
	logic [3:0] chain_q;
	logic [1:0] step_q;
	logic [3:0] elem_q;
	logic [1:0] k_q;
	logic ph_q;
	logic ov_q;
	mcpr_pkg::word_t pm_q [9];
	mcpr_pkg::word_t bm_q [9];
	mcpr_pkg::word_t nm_q [9];
	mcpr_pkg::acc_t acc_q [9];
	mcpr_pkg::word_t col_q [3];
	mcpr_pkg::word_t v_q [6];
	mcpr_pkg::acc_t sum_q;
	logic signed [47:0] scalar_q;
	logic res_ov_q;
	logic res_valid_q;
	logic out_fire;
	logic [1:0] r_e;
	logic [1:0] c_e;
	logic sov;
	mcpr_pkg::word_t swd;
	mcpr_pkg::acc_t ext;
	logic [3:0] cmat;
	logic [1:0] ca;
	mcpr_pkg::word_t sat_nm [9];
	logic [8:0] sat_ov;

	assign in_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res_scalar = scalar_q;
	assign res_ov = res_ov_q;
	assign out_fire = (state_q == S_OUT) && (!res_valid_q || res_ready);
	assign ca = (alpha_q == 2'd0) ? 2'd0 : alpha_q - 2'd1;
	assign cmat = mcpr_pkg::chain_mat(chain_q, step_q);
	assign r_e = (elem_q >= 4'd6) ? 2'd2 : (elem_q >= 4'd3) ? 2'd1 : 2'd0;
	assign c_e = 2'(elem_q - 4'(r_e) * 4'd3);

	// store write: loads and clearing pass
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = value;
		if (state_q == S_CLR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q[mcpr_pkg::ADDR_BITS-1:0];
			ram_wdata = '0;
		end else if (in_valid && in_ready && command == mcpr_pkg::CMD_LOAD
				&& target != mcpr_pkg::T_NONE && row != 2'd3) begin
			if (target <= mcpr_pkg::M_A0) begin
				ram_we = (column != 2'd3);
				ram_waddr = mcpr_pkg::mat_addr(target, row, column);
			end else begin
				ram_we = 1'b1;
				ram_waddr = mcpr_pkg::ADDR_BITS'(mcpr_pkg::VEC1_BASE)
					+ ((target == mcpr_pkg::T_VEC2) ? 7'd3 : 7'd0) + 7'(row);
			end
		end
	end

	// store read address
	always_comb begin
		case (state_q)
			S_COL: ram_raddr = mcpr_pkg::mat_addr(mcpr_pkg::M_A0, cnt_q[1:0], ca);
			S_LDA, S_LDB: ram_raddr = mcpr_pkg::mat_addr(cmat, cnt_q >= 4'd6 ? 2'd2 :
				cnt_q >= 4'd3 ? 2'd1 : 2'd0, 2'(cnt_q - (cnt_q >= 4'd6 ? 4'd6 :
				cnt_q >= 4'd3 ? 4'd3 : 4'd0)));
			S_DOT: ram_raddr = mcpr_pkg::ADDR_BITS'(mcpr_pkg::VEC1_BASE) + 7'(cnt_q);
			default: ram_raddr = '0;
		endcase
	end

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL: begin
				mul_a = pm_q[{2'b0, r_e} * 4'd3 + {2'b0, k_q}];
				mul_b = bm_q[{2'b0, k_q} * 4'd3 + {2'b0, c_e}];
			end
			S_MV: begin
				mul_a = nm_q[{2'b0, r_e} * 4'd3 + {2'b0, k_q}];
				mul_b = col_q[k_q];
			end
			S_DOT: begin
				mul_a = v_q[cnt_q[2:0] - 3'd1];
				mul_b = ram_rdata;
			end
			default: begin
			end
		endcase
		ext = mcpr_pkg::acc_t'(mul_p);
		swd = mcpr_pkg::sat_word(sum_q + (ph_q ? ext : '0), sov);
	end

	// chain sums saturated to word width
	always_comb begin
		for (int i = 0; i < 9; i++) sat_nm[i] = mcpr_pkg::sat_word(acc_q[i], sat_ov[i]);
	end

	// result beat: a new scalar may replace one leaving in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			cnt_q <= '0;
			ph_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (mcpr_pkg::ADDR_BITS+1)'(mcpr_pkg::STORE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid && in_ready && command == mcpr_pkg::CMD_COMPUTE) begin
						alpha_q <= alpha;
						ov_q <= 1'b0;
						cnt_q <= '0;
						chain_q <= '0;
						state_q <= S_COL;
						for (int i = 0; i < 9; i++) acc_q[i] <= '0;
					end
				end
				// coefficient column of a0, read through the registered store port
				S_COL: begin
					if (cnt_q != 4'd0) col_q[cnt_q[1:0] - 2'd1] <= ram_rdata;
					if (cnt_q == 4'd3) begin
						cnt_q <= '0;
						step_q <= 2'd0;
						state_q <= S_LDA;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				// first matrix of a chain into pm
				S_LDA: begin
					if (cnt_q != 4'd0) pm_q[cnt_q - 4'd1] <= ram_rdata;
					if (cnt_q == 4'd9) begin
						cnt_q <= '0;
						step_q <= 2'd1;
						state_q <= S_LDB;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_LDB: begin
					if (cnt_q != 4'd0) bm_q[cnt_q - 4'd1] <= ram_rdata;
					if (cnt_q == 4'd9) begin
						cnt_q <= '0;
						elem_q <= '0;
						k_q <= '0;
						ph_q <= 1'b0;
						sum_q <= '0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				// element products: issue k, collect it in the cycle after
				S_MUL: begin
					if (ph_q) begin
						sum_q <= sum_q + ext;
						ov_q <= ov_q | mul_ov;
					end
					ph_q <= 1'b1;
					if (k_q == 2'd2) begin
						k_q <= '0;
						state_q <= S_ACC;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_ACC: begin
					nm_q[elem_q] <= swd;
					ov_q <= ov_q | mul_ov | sov;
					sum_q <= '0;
					ph_q <= 1'b0;
					if (elem_q == 4'd8) begin
						elem_q <= '0;
						if (step_q == 2'd3) begin
							state_q <= S_SUM;
						end else begin
							// running product becomes the left operand
							for (int i = 0; i < 8; i++) pm_q[i] <= nm_q[i];
							pm_q[8] <= swd;
							step_q <= step_q + 2'd1;
							state_q <= S_LDB;
						end
					end else begin
						elem_q <= elem_q + 4'd1;
						state_q <= S_MUL;
					end
				end
				S_SUM: begin
					if (cnt_q == 4'd0) begin
						for (int i = 0; i < 9; i++) acc_q[i] <= acc_q[i] + mcpr_pkg::acc_t'(nm_q[i]);
						cnt_q <= 4'd1;
					end else if (chain_q == 4'd7 || chain_q == 4'd11) begin
						cnt_q <= '0;
						for (int i = 0; i < 9; i++) begin
							nm_q[i] <= sat_nm[i];
							acc_q[i] <= '0;
						end
						ov_q <= ov_q | (|sat_ov);
						elem_q <= '0;
						k_q <= '0;
						ph_q <= 1'b0;
						sum_q <= '0;
						state_q <= S_MV;
					end else begin
						cnt_q <= '0;
						chain_q <= chain_q + 4'd1;
						step_q <= 2'd0;
						state_q <= S_LDA;
					end
				end
				// matrix times column, rows in elem 0,3,6
				S_MV: begin
					if (k_q == 2'd2 && ph_q && cnt_q == 4'd1) begin
						v_q[(chain_q == 4'd7 ? 3'd0 : 3'd3) + 3'(r_e)] <= swd;
						ov_q <= ov_q | mul_ov | sov;
						sum_q <= '0;
						ph_q <= 1'b0;
						k_q <= '0;
						cnt_q <= '0;
						if (elem_q == 4'd6) begin
							if (chain_q == 4'd7) begin
								chain_q <= 4'd8;
								step_q <= 2'd0;
								state_q <= S_LDA;
							end else begin
								state_q <= S_DOT;
							end
						end else begin
							elem_q <= elem_q + 4'd3;
						end
					end else begin
						if (ph_q) begin
							sum_q <= sum_q + ext;
							ov_q <= ov_q | mul_ov;
						end
						ph_q <= 1'b1;
						if (k_q == 2'd2) begin
							cnt_q <= 4'd1;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				// six products of v with a1 and a1r, store read issued ahead of use
				S_DOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (ph_q) begin
						sum_q <= sum_q + ext;
						ov_q <= ov_q | mul_ov;
					end
					if (cnt_q == 4'd7) begin
						state_q <= S_OUT;
						ph_q <= 1'b0;
					end else begin
						ph_q <= (cnt_q != 4'd0);
					end
				end
				// wait for the result register to be free
				S_OUT: begin
					if (out_fire) begin
						if (sum_q > 64'sd140737488355327) begin
							scalar_q <= 48'sh7FFF_FFFF_FFFF;
							res_ov_q <= 1'b1;
						end else if (sum_q < -64'sd140737488355328) begin
							scalar_q <= 48'sh8000_0000_0000;
							res_ov_q <= 1'b1;
						end else begin
							scalar_q <= sum_q[47:0];
							res_ov_q <= ov_q;
						end
						cnt_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready) else $error("accept while busy");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> res_valid_q) else $error("result dropped");
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> res_valid_q) else $error("result not raised");
`endif
endmodule

[src/matrix_chain_product_rule_scalar_top.sv]
// top level: chain product scalar block
// Usage: s_axis carries load or compute commands; a load writes one element of
// the 128-entry store. A compute runs twelve four-matrix chains (three matrix
// products each, one shared multiplier, product elements of three terms), chain
// sums, two matrix-vector products and a six-term dot product; s_axis_tready
// is low meanwhile. Loads are taken while a scalar waits on m_axis; a second
// compute runs but holds in its final step until the earlier result beat has
// gone. After reset a clearing pass zeroes the store before the first item is
// taken. When the receiver stalls the result holds. Loads give no result beat.
`timescale 1ns / 1ps
module matrix_chain_product_rule_scalar_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // target[3:0], row[5:4], column[7:6], value[39:8]
	input  logic [2:0]  s_axis_tuser,  // command[0], alpha[2:1]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // scalar[47:0]
	output logic        m_axis_tuser   // overflow
);
	logic ram_we;
	logic [mcpr_pkg::ADDR_BITS-1:0] ram_waddr;
	logic [mcpr_pkg::ADDR_BITS-1:0] ram_raddr;
	mcpr_pkg::word_t ram_wdata;
	mcpr_pkg::word_t ram_rdata;
	mcpr_pkg::word_t mul_a;
	mcpr_pkg::word_t mul_b;
	mcpr_pkg::word_t mul_p;
	logic mul_ov;
	logic signed [47:0] scalar;

	assign m_axis_tdata = scalar;

	mcpr_ram #(.WIDTH(mcpr_pkg::WORD_BITS), .DEPTH(mcpr_pkg::STORE_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	mcpr_mac u_mac (.clk(clk), .a(mul_a), .b(mul_b), .prod_s1(mul_p), .ov_s1(mul_ov));

	mcpr_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.command(s_axis_tuser[0]), .target(s_axis_tdata[3:0]),
		.row(s_axis_tdata[5:4]), .column(s_axis_tdata[7:6]),
		.value(s_axis_tdata[39:8]), .alpha(s_axis_tuser[2:1]),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_scalar(scalar), .res_ov(m_axis_tuser),
		.ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
		.mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p), .mul_ov(mul_ov)
	);
endmodule
